/* hdl/pn_pkg.sv */
// Package for the peak normalizer: store sizing, data widths and the
// command/status structs between controller and datapath. No dependencies.
package pn_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MAG_W       = 17;
  localparam int unsigned QUO_W       = 15;
  localparam int unsigned STEP_W      = $clog2(QUO_W);

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic out_load;
    logic clear;
  } pn_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic idx_last;
  } pn_sts_t;

endpackage

/* hdl/peak_normalizer_core.sv */
// Peak normalizer top level: block peak search and normalization to Q2.14.
// Depends on pn_pkg, pn_ctrl and pn_datapath.
//
// Usage:
//   Input stream (s_axis): one signed Q1.15 sample per item, tlast marks the
//   final sample of a block. Samples are taken one per cycle while loading.
//   Up to 64 samples are stored; later ones are dropped and flag overflow.
//   Output stream (m_axis): after the last input item, one Q2.14 result per
//   stored sample, each divided by the signed peak (peak maps to +16384).
//   tlast marks the final result; tuser carries all_zero and overflow.
//   After the last input item, each result passes through a store read, a
//   divider start, the 15-step divider, a done check and an output load, one
//   result at a time. The input is not ready during emission; loading of the
//   next block starts while the final result is still held.
//   A stalled receiver holds the output register and pauses emission.
//   Reset empties the block and clears the output valid; store contents are
//   never read before being written in the current block.
module peak_normalizer_core
  import pn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] normalized
  output logic        m_axis_tlast_o,   // is_last_res
  output logic [1:0]  m_axis_tuser_o    // [0] all_zero, [1] overflow
);

  pn_cmd_t cmd;
  pn_sts_t sts;
  logic    out_zero;
  logic    out_ovf;

  pn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pn_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_zero_o  (out_zero),
    .out_ovf_o   (out_ovf)
  );

  assign m_axis_tuser_o = {out_ovf, out_zero};

endmodule

/* hdl/pn_div.sv */
// Iterative restoring divider for the peak normalizer: one quotient bit a cycle.
// Computes trunc(dvd * 2^14 / dvs) for dvd <= dvs, sign applied at the end.
// Depends on pn_pkg.
module pn_div
  import pn_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SAMPLE_W-1:0]        dvd_i,
  input  logic [SAMPLE_W-1:0]        dvs_i,
  input  logic                       neg_i,
  output logic signed [SAMPLE_W-1:0] quo_o,
  output logic                       done_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [SAMPLE_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic                neg_q, neg_d;

  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   diff;
  logic                ge;
  logic [SAMPLE_W-1:0] quo_ext;

  always_comb begin
    trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = '0;
      rem_d  = dvd_i;
      dvs_d  = dvs_i;
      quo_d  = '0;
      neg_d  = neg_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      if (step_q == STEP_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign quo_ext = SAMPLE_W'(quo_q);
  assign quo_o   = neg_q ? -$signed(quo_ext) : $signed(quo_ext);
  assign done_o  = done_q;

endmodule

/* hdl/pn_datapath.sv */
// Datapath of the peak normalizer: sample store, peak tracking, read index,
// divider and output register. Depends on pn_pkg and pn_div.
module pn_datapath
  import pn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pn_cmd_t             cmd_i,
  output pn_sts_t             sts_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SAMPLE_W-1:0] out_data_o,
  output logic                out_last_o,
  output logic                out_zero_o,
  output logic                out_ovf_o
);

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [MAG_W-1:0]    peak_mag_q, peak_mag_d;
  logic [SAMPLE_W-1:0] peak_q, peak_d;
  logic                drop_q, drop_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_data_q;
  logic                out_last_q, out_zero_q, out_ovf_q;

  logic                has_room;
  logic [MAG_W-1:0]    mag;
  logic [SAMPLE_W-1:0] rd_mag;
  logic [SAMPLE_W-1:0] peak_abs;
  logic signed [SAMPLE_W-1:0] quo;
  logic                div_done;
  logic                all_zero;
  logic                idx_last;

  assign has_room = count_q < CNT_W'(STORE_DEPTH);
  assign mag      = sample_i[SAMPLE_W-1] ? -MAG_W'($signed(sample_i))
                                         : MAG_W'($signed(sample_i));
  assign rd_mag   = rd_data_q[SAMPLE_W-1] ? -rd_data_q : rd_data_q;
  assign peak_abs = peak_q[SAMPLE_W-1] ? -peak_q : peak_q;
  assign all_zero = peak_mag_q == '0;
  assign idx_last = (CNT_W'(idx_q) + 1'b1) == count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      mem[count_q[ADDR_W-1:0]] <= sample_i;
    end
    rd_data_q <= mem[idx_q];
  end

  always_comb begin
    count_d    = count_q;
    peak_mag_d = peak_mag_q;
    peak_d     = peak_q;
    drop_d     = drop_q;
    if (cmd_i.clear) begin
      count_d    = '0;
      peak_mag_d = '0;
      peak_d     = '0;
      drop_d     = 1'b0;
    end else if (cmd_i.load) begin
      if (has_room) begin
        count_d = count_q + 1'b1;
        if (mag > peak_mag_q) begin
          peak_mag_d = mag;
          peak_d     = sample_i;
        end
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      peak_mag_q  <= '0;
      peak_q      <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      peak_mag_q  <= peak_mag_d;
      peak_q      <= peak_d;
      drop_q      <= drop_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= all_zero ? '0 : quo;
      out_last_q <= idx_last;
      out_zero_q <= all_zero;
      out_ovf_q  <= drop_q;
    end
  end

  pn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (rd_mag),
    .dvs_i   (peak_abs),
    .neg_i   (rd_data_q[SAMPLE_W-1] ^ peak_q[SAMPLE_W-1]),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.idx_last = idx_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_zero_o  = out_zero_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

/* hdl/pn_ctrl.sv */
// Controller of the peak normalizer: load phase, then one read, divide and
// output pass per stored sample. Depends on pn_pkg.
module pn_ctrl
  import pn_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  pn_sts_t sts_i,
  output pn_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_READ  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } pn_state_e;

  pn_state_e state_q, state_d;
  logic      accept;

  assign in_ready_o = state_q == S_LOAD;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = accept;
        if (accept && in_last_i) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        state_d = S_START;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
